// File: rtl/core/sdcg_pkg.sv
// ----------------------------------------------------------------------------
// sdcg_pkg: shared types and constants
// Field widths, mode and kind codes, pipeline item and command structs, and
// the sector helpers of the sprite draw command generator.
// ----------------------------------------------------------------------------
package sdcg_pkg;

  localparam int unsigned FRAME_DEPTH_DEFAULT = 4096;

  localparam int unsigned IDX_IN_W  = 12;
  localparam int unsigned SUM_W     = 13;
  localparam int unsigned REC_W     = 56;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned SCR_W     = 17;
  localparam int unsigned PIV_W     = 9;
  localparam int unsigned ANG_W     = 10;
  localparam int unsigned ROT_W     = 9;
  localparam int unsigned SECT_W    = 4;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned S_TDATA_W = 152;
  localparam int unsigned M_TDATA_W = 112;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_DRAW  = 1'b1;

  localparam logic [ROT_W-1:0] HALF_TURN    = 9'd256;
  localparam logic [ANG_W-1:0] SECTOR_BIAS  = 10'd20;
  localparam logic [ANG_W-1:0] REVERSE_BIAS = 10'd532;
  localparam logic [SECT_W-1:0] FULL_SECTORS = 4'd8;
  localparam logic [ANG_W-1:0] ANGLE_0      = 10'd0;
  localparam logic [ANG_W-1:0] ANGLE_90     = 10'd128;
  localparam logic [ANG_W-1:0] ANGLE_180    = 10'd256;
  localparam logic [ANG_W-1:0] ANGLE_270    = 10'd384;

  typedef enum logic [1:0] {
    MODE_FLIP   = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_SNAP   = 2'd2,
    MODE_SECTOR = 2'd3
  } rot_mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_FLIP   = 2'd1,
    KIND_ROTATE = 2'd2
  } draw_kind_e;

  typedef struct packed {
    logic                     func;
    rot_mode_e                mode;
    logic [BYTE_W-1:0]        direction;
    logic [ANG_W-1:0]         angle;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [REC_W-1:0]         record;
  } item_t;

  typedef struct packed {
    draw_kind_e               kind;
    logic signed [SCR_W-1:0]  screen_x;
    logic signed [SCR_W-1:0]  screen_y;
    logic signed [PIV_W-1:0]  pivot_x;
    logic signed [PIV_W-1:0]  pivot_y;
    logic [BYTE_W-1:0]        src_width;
    logic [BYTE_W-1:0]        src_height;
    logic [BYTE_W-1:0]        src_left;
    logic [BYTE_W-1:0]        src_top;
    logic [ANG_W-1:0]         angle;
    logic [BYTE_W-1:0]        surface;
    logic [BYTE_W-1:0]        flip;
  } cmd_t;

  // 64-step sector of a rotation, 0..8, with a bias of 20 toward the next one
  function automatic logic [SECT_W-1:0] sector_of(input logic [ROT_W-1:0] rot);
    logic [ANG_W-1:0] t;
    if (rot < HALF_TURN) begin
      t = {1'b0, rot} + SECTOR_BIAS;
      return SECT_W'(t >> 6);
    end else begin
      t = REVERSE_BIAS - {1'b0, rot};
      return FULL_SECTORS - SECT_W'(t >> 6);
    end
  endfunction

  // eight-sector angle; odd sectors snap back unless the object is straight
  function automatic logic [ANG_W-1:0] sector_angle(input logic [SECT_W-1:0] sector,
                                                    input logic straight);
    logic [ANG_W-1:0] a;
    unique case (sector)
      4'd1:    a = straight ? ANGLE_90  : ANGLE_0;
      4'd2:    a = ANGLE_90;
      4'd3:    a = straight ? ANGLE_180 : ANGLE_90;
      4'd4:    a = ANGLE_180;
      4'd5:    a = straight ? ANGLE_270 : ANGLE_180;
      4'd6:    a = ANGLE_270;
      4'd7:    a = straight ? ANGLE_0   : ANGLE_270;
      default: a = ANGLE_0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/sdcg_index_unit.sv
// ----------------------------------------------------------------------------
// sdcg_index_unit: request decode and table index reduction
// Works out the angle and the raw table index of a request, then reduces the
// index modulo the table depth by a reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module sdcg_index_unit
  import sdcg_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(FRAME_DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic                    valid_i,
  input  logic                    func_i,
  input  logic [IDX_IN_W-1:0]     write_index_i,
  input  logic [REC_W-1:0]        frame_record_i,
  input  logic [IDX_IN_W-1:0]     list_offset_i,
  input  logic [BYTE_W-1:0]       frame_i,
  input  logic [BYTE_W-1:0]       frame_count_i,
  input  logic [1:0]              rotation_mode_i,
  input  logic [BYTE_W-1:0]       direction_i,
  input  logic [ROT_W-1:0]        rotation_i,
  input  logic signed [POS_W-1:0] x_pos_i,
  input  logic signed [POS_W-1:0] y_pos_i,
  output logic                    valid_o,
  output item_t                   item_o,
  output logic [AW-1:0]           addr_o
);

  localparam int unsigned MOD_SHIFT = SUM_W + AW;
  localparam int unsigned RECIP_W   = SUM_W + 2;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP64   = (64'd1 << MOD_SHIFT) / 64'(FRAME_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  rot_mode_e         mode;
  logic [SECT_W-1:0] sector;
  logic [SUM_W-1:0]  alt_add;
  logic [SUM_W-1:0]  sum;
  item_t             item;

  logic              valid_a_q, valid_b_q;
  logic [SUM_W-1:0]  sum_a_q, sum_b_q;
  item_t             item_a_q, item_b_q;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;
  logic [SUM_W-1:0]  quot_b_q;
  logic [31:0]       rem;

  always_comb begin
    mode   = rot_mode_e'(rotation_mode_i);
    sector = sector_of(rotation_i);
    alt_add = ((mode == MODE_SECTOR) && sector[0]) ? SUM_W'(frame_count_i) : '0;
    if (func_i == FUNC_WRITE) begin
      sum = SUM_W'(write_index_i);
    end else begin
      sum = SUM_W'(list_offset_i) + SUM_W'(frame_i) + alt_add;
    end
    item.func      = func_i;
    item.mode      = mode;
    item.direction = direction_i;
    item.x         = x_pos_i;
    item.y         = y_pos_i;
    item.record    = frame_record_i;
    unique case (mode)
      MODE_SECTOR: item.angle = sector_angle(sector, direction_i == '0);
      MODE_SNAP:   item.angle = {sector, 6'b0};
      MODE_ROTATE: item.angle = {1'b0, rotation_i};
      MODE_FLIP:   item.angle = ANGLE_0;
    endcase
  end

  // quotient estimate is the true quotient or one below it
  assign prod = PROD_W'(sum_a_q) * PROD_W'(RECIP);
  assign quot = SUM_W'(prod >> MOD_SHIFT);

  always_comb begin
    rem = 32'(sum_b_q) - 32'(quot_b_q) * 32'(FRAME_DEPTH);
    if (rem >= 32'(FRAME_DEPTH)) begin
      rem = rem - 32'(FRAME_DEPTH);
    end
    addr_o = AW'(rem);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (advance_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sum_a_q  <= sum;
      item_a_q <= item;
      sum_b_q  <= sum_a_q;
      quot_b_q <= quot;
      item_b_q <= item_a_q;
    end
  end

  assign valid_o = valid_b_q;
  assign item_o  = item_b_q;

endmodule

// File: rtl/core/sdcg_frame_ram.sv
// ----------------------------------------------------------------------------
// sdcg_frame_ram: frame record table
// Single-port synchronous memory of packed frame records, registered read.
// ----------------------------------------------------------------------------
module sdcg_frame_ram
  import sdcg_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(FRAME_DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [REC_W-1:0] wdata_i,
  output logic [REC_W-1:0] rdata_o
);

  logic [REC_W-1:0] mem [FRAME_DEPTH];
  logic [REC_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sdcg_cmd_build.sv
// ----------------------------------------------------------------------------
// sdcg_cmd_build: draw command assembly
// Unpacks the frame record, places the blit and holds the command in the
// output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module sdcg_cmd_build
  import sdcg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [REC_W-1:0] record_i,
  output logic             valid_o,
  output cmd_t             cmd_o
);

  logic [BYTE_W-1:0]       left, top, w, h, surf;
  logic signed [BYTE_W-1:0] px, py;
  logic signed [SCR_W-1:0] x17, y17, w17, h17, px17, py17;
  cmd_t                    cmd;
  logic                    valid_q;
  cmd_t                    cmd_q;

  always_comb begin
    left = record_i[7:0];
    top  = record_i[15:8];
    w    = record_i[23:16];
    h    = record_i[31:24];
    px   = $signed(record_i[39:32]);
    py   = $signed(record_i[47:40]);
    surf = record_i[55:48];
    x17  = SCR_W'(item_i.x);
    y17  = SCR_W'(item_i.y);
    w17  = $signed({9'b0, w});
    h17  = $signed({9'b0, h});
    px17 = SCR_W'(px);
    py17 = SCR_W'(py);

    cmd = '0;
    if (item_i.func == FUNC_DRAW) begin
      if (item_i.mode == MODE_FLIP) begin
        if (item_i.direction[7:2] == '0) begin
          cmd.kind     = KIND_FLIP;
          cmd.screen_x = item_i.direction[0] ? (x17 - w17 - px17) : (x17 + px17);
          cmd.screen_y = item_i.direction[1] ? (y17 - h17 - py17) : (y17 + py17);
        end
      end else begin
        cmd.kind     = KIND_ROTATE;
        cmd.screen_x = x17;
        cmd.screen_y = y17;
        cmd.pivot_x  = -PIV_W'(px);
        cmd.pivot_y  = -PIV_W'(py);
        cmd.angle    = item_i.angle;
      end
      if (cmd.kind != KIND_NONE) begin
        cmd.src_width  = w;
        cmd.src_height = h;
        cmd.src_left   = left;
        cmd.src_top    = top;
        cmd.surface    = surf;
        cmd.flip       = item_i.direction;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      cmd_q <= cmd;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

// File: rtl/core/sprite_draw_command_generator_core.sv
// ----------------------------------------------------------------------------
// sprite_draw_command_generator_core: sprite draw command generator
// Frame record table plus draw command generation, one request per cycle when not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests. tuser selects the kind: 0 stores frame_record at
//   write_index, 1 draws from entry list_offset + frame (+ frame_count for the
//   odd sectors of eight-sector mode), indices wrapping at FRAME_DEPTH.
//   m_axis carries one command per request, in order; writes and suppressed
//   flipped draws come out as an all-zero command of kind none.
//   Throughput is one request per cycle while no command waits at m_axis.
//   A request runs through index add, reciprocal modulo multiply, index
//   correction with the table read, then command assembly, each one stage.
//   The pipeline stalls as a whole while a command waits at m_axis;
//   s_axis_tready follows from the output register being free or taken.
//   Reset clears the pipeline valids only; table entries are undefined until
//   written and need no clearing pass.
// ----------------------------------------------------------------------------
module sprite_draw_command_generator_core
  import sdcg_pkg::*;
#(
  parameter int unsigned FRAME_DEPTH = FRAME_DEPTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // write_index, frame_record, list_offset, frame, frame_count, rotation_mode,
  // direction, rotation, x_pos, y_pos
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // screen_x, screen_y, pivot_x, pivot_y, src_width, src_height, src_left,
  // src_top, angle, surface, flip
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // draw_kind
  output logic [KIND_W-1:0]    m_axis_tuser
);

  localparam int unsigned AW = $clog2(FRAME_DEPTH);

  logic             advance;
  logic             valid_b;
  item_t            item_b;
  logic [AW-1:0]    addr_b;
  logic [REC_W-1:0] rdata;
  logic             valid_c_q;
  item_t            item_c_q;
  cmd_t             cmd;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  sdcg_index_unit #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_index (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .valid_i        (s_axis_tvalid),
    .func_i         (s_axis_tuser),
    .write_index_i  (s_axis_tdata[11:0]),
    .frame_record_i (s_axis_tdata[67:12]),
    .list_offset_i  (s_axis_tdata[79:68]),
    .frame_i        (s_axis_tdata[87:80]),
    .frame_count_i  (s_axis_tdata[95:88]),
    .rotation_mode_i(s_axis_tdata[97:96]),
    .direction_i    (s_axis_tdata[105:98]),
    .rotation_i     (s_axis_tdata[114:106]),
    .x_pos_i        ($signed(s_axis_tdata[130:115])),
    .y_pos_i        ($signed(s_axis_tdata[146:131])),
    .valid_o        (valid_b),
    .item_o         (item_b),
    .addr_o         (addr_b)
  );

  sdcg_frame_ram #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (advance && valid_b),
    .we_i   (item_b.func == FUNC_WRITE),
    .addr_i (addr_b),
    .wdata_i(item_b.record),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else if (advance) begin
      valid_c_q <= valid_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      item_c_q <= item_b;
    end
  end

  sdcg_cmd_build u_cmd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .valid_i  (valid_c_q),
    .item_i   (item_c_q),
    .record_i (rdata),
    .valid_o  (m_axis_tvalid),
    .cmd_o    (cmd)
  );

  assign m_axis_tuser = cmd.kind;
  assign m_axis_tdata = {2'b0, cmd.flip, cmd.surface, cmd.angle, cmd.src_top,
                         cmd.src_left, cmd.src_height, cmd.src_width,
                         cmd.pivot_y, cmd.pivot_x, cmd.screen_y, cmd.screen_x};

endmodule

// File: bench/sprite_draw_command_generator_core_tb.sv
// ----------------------------------------------------------------------------
// sprite_draw_command_generator_core_tb: self-checking bench for the core
// Writes four frame table entries, then issues a directed list of draw
// requests followed by random draws and writes, each draw aimed at a written
// entry. Every command is checked field by field against an in-bench
// predictor, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module sprite_draw_command_generator_core_tb
  import sdcg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = FRAME_DEPTH_DEFAULT;
  localparam int RAND_REQS   = 600;
  localparam int CYCLE_LIMIT = 200_000;

  localparam logic [REC_W-1:0] REC_ONES  = 56'hFF_FF_FF_FF_FF_FF_FF;
  localparam logic [REC_W-1:0] REC_NEGPV = 56'h00_80_80_00_00_00_00;
  localparam logic [REC_W-1:0] REC_POSPV = 56'hAA_7F_7F_FF_FF_55_A5;
  localparam logic [REC_W-1:0] REC_MIXED = 56'h5A_01_FE_20_10_33_CC;

  typedef struct packed {
    logic                    func;
    logic [IDX_IN_W-1:0]     widx;
    logic [REC_W-1:0]        rec;
    logic [IDX_IN_W-1:0]     lo;
    logic [BYTE_W-1:0]       frame;
    logic [BYTE_W-1:0]       fc;
    rot_mode_e               mode;
    logic [BYTE_W-1:0]       dir;
    logic [ROT_W-1:0]        rot;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } req_t;

  // zero_cmd: command is all zero, kind none
  typedef struct packed {
    logic zero_cmd;
    req_t req;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]    m_axis_tuser;

  logic [REC_W-1:0]    frame_mem [DEPTH];
  bit                  is_filled [DEPTH];
  logic [IDX_IN_W-1:0] filled_idx [$];
  cmd_t                pending_cmds [$];
  int                  mismatches = 0;
  int                  cycles = 0;
  bit                  steady;

  // fields: func, widx, rec, list offset, frame, frame count, mode, dir, rot, x, y
  row_t dir_rows [24] = '{
    '{1'b1, '{FUNC_WRITE, 12'd0,    REC_ONES,  12'd4095, 8'hFF, 8'hFF, MODE_SECTOR,
              8'hFF, 9'h1FF, 16'hFFFF, 16'hFFFF}},
    '{1'b1, '{FUNC_WRITE, 12'd4095, REC_NEGPV, 12'd0,    8'h00, 8'h00, MODE_FLIP,
              8'h00, 9'h000, 16'h0000, 16'h0000}},
    '{1'b1, '{FUNC_WRITE, 12'd5,    REC_POSPV, 12'd5,    8'h01, 8'h02, MODE_ROTATE,
              8'h01, 9'h055, 16'h1234, 16'h4321}},
    '{1'b1, '{FUNC_WRITE, 12'd2048, REC_MIXED, 12'd2048, 8'h80, 8'h80, MODE_SNAP,
              8'h02, 9'h100, 16'h8000, 16'h7FFF}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd0,   MODE_FLIP,
              8'd0,  9'd0,   16'h7FFF, 16'h8000}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd0,   MODE_FLIP,
              8'd1,  9'd0,   16'h8000, 16'h7FFF}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd5,    8'd0,   8'd0,   MODE_FLIP,
              8'd2,  9'd0,   16'h8000, 16'h8000}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd4095, 8'd0,   8'd0,   MODE_FLIP,
              8'd3,  9'd0,   16'h7FFF, 16'h7FFF}},
    '{1'b1, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd0,   MODE_FLIP,
              8'd4,  9'd0,   16'h0100, 16'h0200}},
    '{1'b1, '{FUNC_DRAW,  12'd0,    '0,        12'd5,    8'd0,   8'd0,   MODE_FLIP,
              8'd255, 9'd0,  16'h0100, 16'h0200}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd4095, 8'd1,   8'd0,   MODE_ROTATE,
              8'd0,  9'd0,   16'h0040, 16'hFFC0}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd5,   8'd0,   MODE_ROTATE,
              8'd1,  9'd511, 16'h8000, 16'h7FFF}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd1793, 8'd255, 8'd0,   MODE_SNAP,
              8'd0,  9'd43,  16'h0010, 16'h0020}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd0,   MODE_SNAP,
              8'd0,  9'd44,  16'h0010, 16'h0020}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd5,    8'd0,   8'd0,   MODE_SNAP,
              8'd3,  9'd255, 16'h0010, 16'h0020}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd4095, 8'd0,   8'd0,   MODE_SNAP,
              8'd0,  9'd256, 16'h0010, 16'h0020}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd2048, 8'd0,   8'd0,   MODE_SNAP,
              8'd0,  9'd511, 16'h0010, 16'h0020}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd255, MODE_SECTOR,
              8'd0,  9'd0,   16'h0333, 16'h0444}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd3591, 8'd255, 8'd255, MODE_SECTOR,
              8'd0,  9'd64,  16'h0333, 16'h0444}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd3591, 8'd255, 8'd255, MODE_SECTOR,
              8'd1,  9'd64,  16'h0333, 16'h0444}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd5,   MODE_SECTOR,
              8'd0,  9'd460, 16'hF000, 16'h0F00}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd4095, 8'd0,   8'd0,   MODE_SECTOR,
              8'd2,  9'd500, 16'hF000, 16'h0F00}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd2000, 8'd40,  8'd8,   MODE_SECTOR,
              8'd0,  9'd300, 16'hF000, 16'h0F00}},
    '{1'b0, '{FUNC_DRAW,  12'd0,    '0,        12'd0,    8'd0,   8'd0,   MODE_SECTOR,
              8'd7,  9'd200, 16'hF000, 16'h0F00}}
  };

  sprite_draw_command_generator_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // 64-step sector, 0..8, of a rotation
  function automatic int rot_sector(input logic [ROT_W-1:0] rot);
    int r;
    r = rot;
    return (r < 256) ? ((r + 20) >> 6) : (8 - ((532 - r) >> 6));
  endfunction

  // stores records on writes; returns the command a request must produce
  function automatic cmd_t draw_command_of(input req_t r);
    cmd_t                c;
    logic [IDX_IN_W-1:0] idx;
    logic [REC_W-1:0]    rec;
    int                  sec, ang, x, y, w, h, px, py, sx, sy;
    c = '0;
    if (r.func == FUNC_WRITE) begin
      frame_mem[r.widx] = r.rec;
      if (!is_filled[r.widx]) begin
        is_filled[r.widx] = 1'b1;
        filled_idx.push_back(r.widx);
      end
      return c;
    end
    idx = r.lo + IDX_IN_W'(r.frame);
    ang = 0;
    case (r.mode)
      MODE_SECTOR: begin
        sec = rot_sector(r.rot);
        case (sec)
          1: ang = (r.dir == 0) ? 128 : 0;
          2: ang = 128;
          3: ang = (r.dir == 0) ? 256 : 128;
          4: ang = 256;
          5: ang = (r.dir == 0) ? 384 : 256;
          6: ang = 384;
          7: ang = (r.dir == 0) ? 0 : 384;
          default: ang = 0;
        endcase
        if (sec % 2 == 1) idx = idx + IDX_IN_W'(r.fc);
      end
      MODE_SNAP: begin
        sec = rot_sector(r.rot);
        ang = (r.rot < 256) ? sec * 64 : 512 - (8 - sec) * 64;
      end
      MODE_ROTATE: ang = r.rot;
      default: ang = 0;
    endcase
    rec = frame_mem[idx];
    w  = rec[23:16];
    h  = rec[31:24];
    px = $signed(rec[39:32]);
    py = $signed(rec[47:40]);
    x  = r.x;
    y  = r.y;
    if (r.mode == MODE_FLIP) begin
      if (r.dir > 3) return c;
      sx = r.dir[0] ? (x - w - px) : (x + px);
      sy = r.dir[1] ? (y - h - py) : (y + py);
      c.kind     = KIND_FLIP;
      c.screen_x = SCR_W'(sx);
      c.screen_y = SCR_W'(sy);
    end else begin
      c.kind     = KIND_ROTATE;
      c.screen_x = SCR_W'(x);
      c.screen_y = SCR_W'(y);
      c.pivot_x  = PIV_W'(-px);
      c.pivot_y  = PIV_W'(-py);
      c.angle    = ANG_W'(ang);
    end
    c.src_width  = rec[23:16];
    c.src_height = rec[31:24];
    c.src_left   = rec[7:0];
    c.src_top    = rec[15:8];
    c.surface    = rec[55:48];
    c.flip       = r.dir;
    return c;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 8);
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("[%0d] %s mismatch: got %h, expected %h", cycles, field, got, want);
  endtask

  task automatic issue_request(input req_t r, input logic zero_cmd);
    cmd_t want;
    while (take_break()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({r.y, r.x, r.rot, r.dir, r.mode, r.fc, r.frame, r.lo,
                                 r.rec, r.widx});
    s_axis_tuser  <= r.func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = draw_command_of(r);
    if (zero_cmd) want = '0;
    pending_cmds.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic check_cmd();
    cmd_t got, want;
    got.kind       = draw_kind_e'(m_axis_tuser);
    got.screen_x   = m_axis_tdata[16:0];
    got.screen_y   = m_axis_tdata[33:17];
    got.pivot_x    = m_axis_tdata[42:34];
    got.pivot_y    = m_axis_tdata[51:43];
    got.src_width  = m_axis_tdata[59:52];
    got.src_height = m_axis_tdata[67:60];
    got.src_left   = m_axis_tdata[75:68];
    got.src_top    = m_axis_tdata[83:76];
    got.angle      = m_axis_tdata[93:84];
    got.surface    = m_axis_tdata[101:94];
    got.flip       = m_axis_tdata[109:102];
    if (pending_cmds.size() == 0) begin
      note_mismatch("unexpected command, draw_kind", got.kind, '0);
      return;
    end
    want = pending_cmds.pop_front();
    if (got.kind !== want.kind) note_mismatch("draw_kind", got.kind, want.kind);
    if (got.screen_x !== want.screen_x) note_mismatch("screen_x", got.screen_x, want.screen_x);
    if (got.screen_y !== want.screen_y) note_mismatch("screen_y", got.screen_y, want.screen_y);
    if (got.pivot_x !== want.pivot_x) note_mismatch("pivot_x", got.pivot_x, want.pivot_x);
    if (got.pivot_y !== want.pivot_y) note_mismatch("pivot_y", got.pivot_y, want.pivot_y);
    if (got.src_width !== want.src_width)
      note_mismatch("src_width", got.src_width, want.src_width);
    if (got.src_height !== want.src_height)
      note_mismatch("src_height", got.src_height, want.src_height);
    if (got.src_left !== want.src_left) note_mismatch("src_left", got.src_left, want.src_left);
    if (got.src_top !== want.src_top) note_mismatch("src_top", got.src_top, want.src_top);
    if (got.angle !== want.angle) note_mismatch("angle", got.angle, want.angle);
    if (got.surface !== want.surface) note_mismatch("surface", got.surface, want.surface);
    if (got.flip !== want.flip) note_mismatch("flip", got.flip, want.flip);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_cmd();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sprite_draw_command_generator_core test failed");
      $finish;
    end
  end

  initial begin
    req_t                r;
    logic [IDX_IN_W-1:0] tgt;
    int                  pick, base;
    bit                  odd;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    steady        = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].zero_cmd);

    for (int n = 0; n < RAND_REQS; n++) begin
      steady = (n >= 150 && n < 300);
      // hold off until the pipe has drained
      if (n == 400) begin
        while (pending_cmds.size() != 0) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk_i);
        end
      end
      r.widx  = IDX_IN_W'($urandom);
      r.rec   = REC_W'({$urandom, $urandom});
      r.lo    = IDX_IN_W'($urandom);
      r.frame = BYTE_W'($urandom);
      r.fc    = BYTE_W'($urandom);
      r.mode  = rot_mode_e'($urandom_range(0, 3));
      r.dir   = BYTE_W'($urandom);
      r.rot   = ROT_W'($urandom);
      r.x     = POS_W'($urandom);
      r.y     = POS_W'($urandom);
      if ($urandom_range(0, 99) < 25) begin
        r.func = FUNC_WRITE;
        if ($urandom_range(0, 3) == 0)
          r.widx = filled_idx[$urandom_range(0, filled_idx.size() - 1)];
      end else begin
        r.func = FUNC_DRAW;
        pick = $urandom_range(0, 99);
        if (pick < 25) r.dir = '0;
        else if (pick < 65) r.dir = BYTE_W'($urandom_range(1, 3));
        // land on sector edges
        if ($urandom_range(0, 4) == 0) begin
          base = $urandom_range(0, 1) ? 64 * $urandom_range(0, 4) - 20
                                      : 532 - 64 * $urandom_range(0, 4);
          r.rot = ROT_W'(base - $urandom_range(0, 1));
        end
        tgt = filled_idx[$urandom_range(0, filled_idx.size() - 1)];
        odd = (r.mode == MODE_SECTOR) && (rot_sector(r.rot) % 2 == 1);
        r.lo = tgt - IDX_IN_W'(r.frame) - (odd ? IDX_IN_W'(r.fc) : '0);
      end
      issue_request(r, 1'b0);
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("sprite_draw_command_generator_core test passed");
    end else begin
      $display("sprite_draw_command_generator_core test failed");
    end
    $finish;
  end

endmodule
